@@ rtl/core/text_console_teletype_core_macros.svh @@
// Assertion macros for the checker of this block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef TEXT_CONSOLE_TELETYPE_CORE_MACROS_SVH
`define TEXT_CONSOLE_TELETYPE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TCON_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("tcon assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TCON_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("tcon assertion failed");

`endif

@@ rtl/core/tcon_pkg.sv @@
`default_nettype none

package tcon_pkg;

  localparam int CMD_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = CHAR_W + ATTR_W;
  localparam int COL_IN_W  = 7;
  localparam int ROW_IN_W  = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] CLEAR_CODE   = 8'h00;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_ATTR      = 2'd0,
    CFG_CURSOR_VISIBLE = 2'd1
  } cfg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_BOOT,
    ST_BOOT_WAIT,
    ST_IDLE,
    ST_PUT,
    ST_READ,
    ST_SWEEP,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    SW_INIT,
    SW_CLEAR,
    SW_SCROLL
  } sweep_mode_t;

  typedef enum logic [1:0] {
    SWS_IDLE,
    SWS_COPY,
    SWS_FILL
  } sweep_state_t;

  typedef struct packed {
    logic        start;
    sweep_mode_t mode;
  } sweep_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/tcon_ifs.sv @@
`default_nettype none

interface tcon_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcon_pkg::CMD_W-1:0]    cmd;
  logic [tcon_pkg::CHAR_W-1:0]   char_code;
  logic [tcon_pkg::COL_IN_W-1:0] col;
  logic [tcon_pkg::ROW_IN_W-1:0] row;

  modport source (output valid, cmd, char_code, col, row, input ready);
  modport sink   (input valid, cmd, char_code, col, row, output ready);
endinterface

interface tcon_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcon_pkg::CHAR_W-1:0]   cell_char;
  logic [tcon_pkg::ATTR_W-1:0]   cell_attr;
  logic [tcon_pkg::COL_IN_W-1:0] cursor_col;
  logic [tcon_pkg::ROW_IN_W-1:0] cursor_row;
  logic                          scrolled;

  modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row, scrolled,
                  input ready);
  modport sink   (input valid, cell_char, cell_attr, cursor_col, cursor_row, scrolled,
                  output ready);
endinterface

interface tcon_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcon_pkg::CFG_IDX_W-1:0] index;
  logic [tcon_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tcon_ram.sv @@
`default_nettype none

module tcon_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/tcon_sweep.sv @@
`default_nettype none

// Whole-screen sweeps: reset clear, clear command, scroll (copy up + blank row).
module tcon_sweep #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic [tcon_pkg::ATTR_W-1:0]            attr,
  input  wire tcon_pkg::sweep_req_t                   req,
  output tcon_pkg::sweep_stat_t                       stat,
  output logic      [$clog2(COLS*ROWS)-1:0]           ram_raddr,
  output logic                                        ram_we,
  output logic      [$clog2(COLS*ROWS)-1:0]           ram_waddr,
  output logic      [tcon_pkg::CELL_W-1:0]            ram_wdata,
  input  wire logic [tcon_pkg::CELL_W-1:0]            ram_rdata
);

  localparam int NCELL = COLS * ROWS;
  localparam int CPY   = COLS * (ROWS - 1);
  localparam int AW    = $clog2(NCELL);

  tcon_pkg::sweep_state_t state, state_next;
  logic [AW-1:0]               cnt;
  logic [AW-1:0]               pend_addr;
  logic                        pend;
  logic [tcon_pkg::CELL_W-1:0] fill_val;
  logic                        copy_end;
  logic                        fill_end;

  assign copy_end = (cnt == AW'(CPY));
  assign fill_end = (cnt == AW'(NCELL - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      tcon_pkg::SWS_IDLE: begin
        if (req.start) begin
          state_next = (req.mode == tcon_pkg::SW_SCROLL) ? tcon_pkg::SWS_COPY
                                                         : tcon_pkg::SWS_FILL;
        end
      end
      tcon_pkg::SWS_COPY: begin
        if (copy_end) begin
          state_next = tcon_pkg::SWS_FILL;
        end
      end
      tcon_pkg::SWS_FILL: begin
        if (fill_end) begin
          state_next = tcon_pkg::SWS_IDLE;
        end
      end
      default: state_next = tcon_pkg::SWS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcon_pkg::SWS_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == tcon_pkg::SWS_COPY) && !copy_end;
    end
  end

  // Copy ends with cnt at the first cell of the last row, where the fill starts.
  always_ff @(posedge clk) begin
    pend_addr <= cnt;
    unique case (state)
      tcon_pkg::SWS_IDLE: begin
        cnt <= '0;
        if (req.start) begin
          unique case (req.mode)
            tcon_pkg::SW_INIT:   fill_val <= '0;
            tcon_pkg::SW_CLEAR:  fill_val <= {attr, tcon_pkg::CLEAR_CODE};
            tcon_pkg::SW_SCROLL: fill_val <= {attr, tcon_pkg::SPACE_CODE};
            default:             fill_val <= '0;
          endcase
        end
      end
      tcon_pkg::SWS_COPY: begin
        if (!copy_end) begin
          cnt <= cnt + AW'(1);
        end
      end
      tcon_pkg::SWS_FILL: begin
        if (!fill_end) begin
          cnt <= cnt + AW'(1);
        end
      end
      default: cnt <= '0;
    endcase
  end

  always_comb begin
    ram_raddr = AW'(cnt + AW'(COLS));
    ram_we    = pend || (state == tcon_pkg::SWS_FILL);
    ram_waddr = pend ? pend_addr : cnt;
    ram_wdata = pend ? ram_rdata : fill_val;
    stat.busy = (state != tcon_pkg::SWS_IDLE);
    stat.done = (state == tcon_pkg::SWS_FILL) && fill_end;
  end

endmodule

`default_nettype wire

@@ rtl/core/text_console_teletype_core.sv @@
`default_nettype none

// Text console, COLS x ROWS cells of {attribute, character}, teletype cursor.
// Channels: in_ch takes commands (put, set cursor, clear, read cell), out_ch
// returns one result per command, cfg_ch writes text_attr (index 0) and
// cursor_visible (index 1); cfg_ch is always ready.
// States from input transaction to the output register, by command:
//   set cursor              IDLE, RESP
//   put (no scroll), read   IDLE, PUT or READ, RESP
//   clear                   IDLE, SWEEP over COLS*ROWS cells (one cell write per cycle), RESP
//   put with scroll         IDLE, PUT, SWEEP (copy COLS*(ROWS-1) cells
//                           through the RAM read port, then blank last row), RESP
// One command is in flight at a time; the single write port of the screen
// RAM sets the sweep lengths. At teletype traffic there is about one scroll
// per COLS characters.
// Reset: the screen RAM is cleared to zero by a sweep of all COLS*ROWS cells
// (2000 at 80x25); in_ch.ready stays low until it finishes.
// Stall: the result sits in the output register; a new command is taken
// meanwhile, and its result waits until the register is freed.
module text_console_teletype_core #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tcon_in_if.sink    in_ch,
  tcon_out_if.source out_ch,
  tcon_cfg_if.sink   cfg_ch
);

  localparam int NCELL = COLS * ROWS;
  localparam int AW    = $clog2(NCELL);
  localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  tcon_pkg::state_t state, state_next;

  // control registers
  logic [tcon_pkg::ATTR_W-1:0] text_attr;
  logic                        cursor_visible;

  // cursor and current command
  logic [COL_W-1:0]            pos_col;
  logic [ROW_W-1:0]            pos_row;
  tcon_pkg::cmd_t              cmd_q;
  logic [tcon_pkg::CHAR_W-1:0] char_q;
  logic [tcon_pkg::CHAR_W-1:0] rd_char;
  logic [tcon_pkg::ATTR_W-1:0] rd_attr;
  logic                        scr_q;

  // output register
  logic                          out_valid;
  logic [tcon_pkg::CHAR_W-1:0]   out_char;
  logic [tcon_pkg::ATTR_W-1:0]   out_attr;
  logic [tcon_pkg::COL_IN_W-1:0] out_col;
  logic [tcon_pkg::ROW_IN_W-1:0] out_row;
  logic                          out_scr;

  // decoded input
  tcon_pkg::cmd_t   in_cmd;
  logic             in_acc;
  logic             out_free;
  logic [COL_W-1:0] sat_col;
  logic [ROW_W-1:0] sat_row;

  // put step
  logic             put_nl;
  logic             put_wrap;
  logic             put_scroll;
  logic [AW-1:0]    pos_addr;

  // RAM ports
  logic [AW-1:0]               ram_raddr, ram_waddr;
  logic                        ram_we;
  logic [tcon_pkg::CELL_W-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0]               sw_raddr, sw_waddr;
  logic                        sw_we;
  logic [tcon_pkg::CELL_W-1:0] sw_wdata;
  logic                        top_we;
  logic [AW-1:0]               rd_addr;

  tcon_pkg::sweep_req_t  sw_req;
  tcon_pkg::sweep_stat_t sw_stat;

  assign in_cmd   = tcon_pkg::cmd_t'(in_ch.cmd);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;

  // out-of-range set/read coordinates clamp to the last column/row
  assign sat_col = (32'(in_ch.col) >= COLS) ? COL_W'(COLS - 1) : COL_W'(in_ch.col);
  assign sat_row = (32'(in_ch.row) >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(in_ch.row);

  assign rd_addr  = AW'(32'(sat_row) * COLS + 32'(sat_col));
  assign pos_addr = AW'(32'(pos_row) * COLS + 32'(pos_col));

  assign put_nl     = (char_q == tcon_pkg::NEWLINE_CODE);
  assign put_wrap   = put_nl || (pos_col == COL_W'(COLS - 1));
  assign put_scroll = put_wrap && (pos_row == ROW_W'(ROWS - 1));

  // ---------------- configuration ----------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr      <= tcon_pkg::ATTR_RESET;
      cursor_visible <= 1'b1;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == tcon_pkg::CFG_TEXT_ATTR) begin
        text_attr <= cfg_ch.data;
      end else if (cfg_ch.index == tcon_pkg::CFG_CURSOR_VISIBLE) begin
        cursor_visible <= cfg_ch.data[0];
      end
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      tcon_pkg::ST_BOOT:      state_next = tcon_pkg::ST_BOOT_WAIT;
      tcon_pkg::ST_BOOT_WAIT: begin
        if (sw_stat.done) begin
          state_next = tcon_pkg::ST_IDLE;
        end
      end
      tcon_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_cmd)
            tcon_pkg::CMD_PUT:   state_next = tcon_pkg::ST_PUT;
            tcon_pkg::CMD_SET:   state_next = tcon_pkg::ST_RESP;
            tcon_pkg::CMD_CLEAR: state_next = tcon_pkg::ST_SWEEP;
            tcon_pkg::CMD_READ:  state_next = tcon_pkg::ST_READ;
            default:             state_next = tcon_pkg::ST_IDLE;
          endcase
        end
      end
      tcon_pkg::ST_PUT:   state_next = put_scroll ? tcon_pkg::ST_SWEEP : tcon_pkg::ST_RESP;
      tcon_pkg::ST_READ:  state_next = tcon_pkg::ST_RESP;
      tcon_pkg::ST_SWEEP: begin
        if (sw_stat.done) begin
          state_next = tcon_pkg::ST_RESP;
        end
      end
      tcon_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = tcon_pkg::ST_IDLE;
        end
      end
      default: state_next = tcon_pkg::ST_BOOT;
    endcase
  end

  always_comb begin
    in_ch.ready   = (state == tcon_pkg::ST_IDLE);
    sw_req.start  = 1'b0;
    sw_req.mode   = tcon_pkg::SW_INIT;
    top_we        = 1'b0;
    unique case (state)
      tcon_pkg::ST_BOOT: begin
        sw_req.start = 1'b1;
        sw_req.mode  = tcon_pkg::SW_INIT;
      end
      tcon_pkg::ST_IDLE: begin
        sw_req.start = in_ch.valid && (in_cmd == tcon_pkg::CMD_CLEAR);
        sw_req.mode  = tcon_pkg::SW_CLEAR;
      end
      tcon_pkg::ST_PUT: begin
        top_we       = !put_nl;
        sw_req.start = put_scroll;
        sw_req.mode  = tcon_pkg::SW_SCROLL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tcon_pkg::ST_BOOT;
      pos_col <= '0;
      pos_row <= '0;
    end else begin
      state <= state_next;
      if (in_acc && in_cmd == tcon_pkg::CMD_SET) begin
        pos_col <= sat_col;
        pos_row <= sat_row;
      end else if (in_acc && in_cmd == tcon_pkg::CMD_CLEAR) begin
        pos_col <= '0;
        pos_row <= '0;
      end else if (state == tcon_pkg::ST_PUT) begin
        // newline or last column: start of next row; the last row stays put
        pos_col <= put_wrap ? '0 : COL_W'(pos_col + COL_W'(1));
        if (put_wrap && !put_scroll) begin
          pos_row <= ROW_W'(pos_row + ROW_W'(1));
        end
      end
    end
  end

  // command payload and read capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q   <= in_cmd;
      char_q  <= in_ch.char_code;
      rd_char <= '0;
      rd_attr <= '0;
      scr_q   <= 1'b0;
    end else if (state == tcon_pkg::ST_READ) begin
      rd_char <= ram_rdata[tcon_pkg::CHAR_W-1:0];
      rd_attr <= ram_rdata[tcon_pkg::CELL_W-1:tcon_pkg::CHAR_W];
    end else if (state == tcon_pkg::ST_PUT) begin
      scr_q <= put_scroll;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tcon_pkg::ST_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tcon_pkg::ST_RESP && out_free) begin
      out_char <= rd_char;
      out_attr <= rd_attr;
      out_col  <= cursor_visible ? tcon_pkg::COL_IN_W'(pos_col)
                                 : tcon_pkg::COL_IN_W'(COLS);
      out_row  <= tcon_pkg::ROW_IN_W'(pos_row);
      out_scr  <= (cmd_q == tcon_pkg::CMD_PUT) && scr_q;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.cell_char  = out_char;
  assign out_ch.cell_attr  = out_attr;
  assign out_ch.cursor_col = out_col;
  assign out_ch.cursor_row = out_row;
  assign out_ch.scrolled   = out_scr;

  // ---------------- screen memory ----------------
  // Sweeps own both ports while busy; otherwise reads come from the accepted
  // read command and writes from the put step.
  assign ram_raddr = sw_stat.busy ? sw_raddr : rd_addr;
  assign ram_we    = sw_we || top_we;
  assign ram_waddr = sw_stat.busy ? sw_waddr : pos_addr;
  assign ram_wdata = sw_stat.busy ? sw_wdata : {text_attr, char_q};

  tcon_sweep #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_sweep (
    .clk       (clk),
    .rst       (rst),
    .attr      (text_attr),
    .req       (sw_req),
    .stat      (sw_stat),
    .ram_raddr (sw_raddr),
    .ram_we    (sw_we),
    .ram_waddr (sw_waddr),
    .ram_wdata (sw_wdata),
    .ram_rdata (ram_rdata)
  );

  tcon_ram #(
    .WIDTH(tcon_pkg::CELL_W),
    .DEPTH(NCELL)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

@@ rtl/core/tcon_checker.sv @@
`default_nettype none

`include "text_console_teletype_core_macros.svh"

module tcon_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [tcon_pkg::CHAR_W-1:0]   cell_char,
  input wire logic [tcon_pkg::COL_IN_W-1:0] cursor_col,
  input wire logic [tcon_pkg::ROW_IN_W-1:0] cursor_row,
  input wire logic                          scrolled
);

  // a stalled result holds
  `TCON_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cell_char))

  // cursor row stays on screen
  `TCON_ASSERT_NOW(a_row_range, out_valid, 32'(cursor_row) < ROWS)

  // a scroll leaves the cursor at the start of the last row (or hidden)
  `TCON_ASSERT_NOW(a_scroll_pos, out_valid && scrolled,
    (32'(cursor_row) == ROWS - 1) &&
    (cursor_col == '0 || cursor_col == tcon_pkg::COL_IN_W'(COLS)))

  // a scroll only comes from a put, which never returns cell data
  `TCON_ASSERT_NOW(a_scroll_nodata, out_valid && scrolled, cell_char == '0)

endmodule

bind text_console_teletype_core tcon_checker #(
  .COLS(COLS),
  .ROWS(ROWS)
) u_tcon_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .cell_char  (out_ch.cell_char),
  .cursor_col (out_ch.cursor_col),
  .cursor_row (out_ch.cursor_row),
  .scrolled   (out_ch.scrolled)
);

`default_nettype wire

@@ verif/tcon_screen_checker.sv @@
`default_nettype none

// Watches the three channels, keeps a shadow screen and cursor, and checks
// every result transaction against the oldest awaited one.
module tcon_screen_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic clk,
  input  wire logic rst,
  tcon_in_if        in_ch,
  tcon_out_if       out_ch,
  tcon_cfg_if       cfg_ch,
  output int        failures,
  output int        outstanding
);
  import tcon_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0]   cell_char;
    logic [ATTR_W-1:0]   cell_attr;
    logic [COL_IN_W-1:0] cursor_col;
    logic [ROW_IN_W-1:0] cursor_row;
    logic                scrolled;
  } console_result_t;

  logic [CELL_W-1:0] screen [COLS*ROWS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [ATTR_W-1:0] attr_reg;
  logic              visible_reg;
  console_result_t   awaited [$];

  function automatic int unsigned clamp(int unsigned v, int unsigned lim);
    return (v >= lim) ? lim - 1 : v;
  endfunction

  // Applies one command to the shadow state and returns its result.
  function automatic console_result_t console_step(logic [CMD_W-1:0] cmd,
                                                   logic [CHAR_W-1:0] ch,
                                                   logic [COL_IN_W-1:0] cl,
                                                   logic [ROW_IN_W-1:0] rw);
    console_result_t r;
    int unsigned     i;
    int unsigned     c;
    int unsigned     w;
    r = '0;
    case (cmd_t'(cmd))
      CMD_PUT: begin
        if (ch == NEWLINE_CODE) begin
          cur_col = COLS;
        end else begin
          screen[cur_row*COLS + cur_col] = {attr_reg, ch};
          cur_col++;
        end
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (i = 0; i < COLS*(ROWS-1); i++) screen[i] = screen[i+COLS];
          for (i = COLS*(ROWS-1); i < COLS*ROWS; i++) screen[i] = {attr_reg, SPACE_CODE};
          cur_row    = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      CMD_SET: begin
        cur_col = clamp(cl, COLS);
        cur_row = clamp(rw, ROWS);
      end
      CMD_CLEAR: begin
        for (i = 0; i < COLS*ROWS; i++) screen[i] = {attr_reg, CLEAR_CODE};
        cur_col = 0;
        cur_row = 0;
      end
      default: begin
        c = clamp(cl, COLS);
        w = clamp(rw, ROWS);
        {r.cell_attr, r.cell_char} = screen[w*COLS + c];
      end
    endcase
    r.cursor_col = visible_reg ? COL_IN_W'(cur_col) : COL_IN_W'(COLS);
    r.cursor_row = ROW_IN_W'(cur_row);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      foreach (screen[i]) screen[i] = '0;
      cur_col     = 0;
      cur_row     = 0;
      attr_reg    = ATTR_RESET;
      visible_reg = 1'b1;
      awaited.delete();
    end else begin
      // results first: a command taken this edge cannot have its result yet
      if (out_ch.valid && out_ch.ready) begin
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result, expected none, got char %0d attr %0d col %0d row %0d",
                   $time, out_ch.cell_char, out_ch.cell_attr, out_ch.cursor_col,
                   out_ch.cursor_row);
          failures++;
        end else begin
          want = awaited.pop_front();
          check_field("cell_char", want.cell_char, out_ch.cell_char);
          check_field("cell_attr", want.cell_attr, out_ch.cell_attr);
          check_field("cursor_col", want.cursor_col, out_ch.cursor_col);
          check_field("cursor_row", want.cursor_row, out_ch.cursor_row);
          check_field("scrolled", want.scrolled, out_ch.scrolled);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_TEXT_ATTR) attr_reg = cfg_ch.data;
        else if (cfg_ch.index == CFG_CURSOR_VISIBLE) visible_reg = cfg_ch.data[0];
      end
      if (in_ch.valid && in_ch.ready)
        awaited.push_back(console_step(in_ch.cmd, in_ch.char_code, in_ch.col, in_ch.row));
    end
    outstanding = awaited.size();
  end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none

// Top: makes the command and config stimulus, drives both ends of the
// handshakes, and gives the verdict. All checking sits in tcon_screen_checker.
module tb;
  import tcon_pkg::*;

  localparam int COLS         = 80;
  localparam int ROWS         = 25;
  // a clear or a scroll sweeps every cell once; wait this long at the end
  localparam int SWEEP_CYCLES = COLS*ROWS + 10;
  // worst case: every command a full sweep plus stalls, taken about 3x over
  localparam int CYCLE_LIMIT  = 9_000_000;

  bit   clk;
  logic rst = 1'b1;
  bit   idle_on = 1'b1;   // random gaps on the sender and stalls on the receiver
  int   sent;             // accepted command transactions
  int   cycles;
  int   failures;
  int   outstanding;

  tcon_in_if  in_ch ();
  tcon_out_if out_ch ();
  tcon_cfg_if cfg_ch ();

  text_console_teletype_core #(.COLS(COLS), .ROWS(ROWS)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tcon_screen_checker #(.COLS(COLS), .ROWS(ROWS)) chk (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: stall about 31% of cycles while idling is on.
  always @(negedge clk) begin
    out_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 31);
  end

  // Hang guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // One command transaction. Entered and left at a falling edge; valid stays
  // high into the next call unless a gap is drawn, so back-to-back commands
  // never see valid dropped and raised in one step.
  task automatic send_cmd(input cmd_t c, input logic [CHAR_W-1:0] ch,
                          input logic [COL_IN_W-1:0] cl, input logic [ROW_IN_W-1:0] rw);
    if (idle_on && $urandom_range(0, 99) < 31) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < 31) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= c;
    in_ch.char_code <= ch;
    in_ch.col       <= cl;
    in_ch.row       <= rw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Stop sending and let every awaited result come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Register write; only called with the core idle.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly in range, a quarter of the time anywhere the field allows.
  function automatic int pick_coord(input int span, input int full_span);
    return ($urandom_range(0, 3) != 0) ? $urandom_range(0, span - 1)
                                       : $urandom_range(0, full_span - 1);
  endfunction

  // A run of characters as a terminal would print them, with newlines.
  task automatic type_text(input int n);
    repeat (n) begin
      send_cmd(CMD_PUT,
               ($urandom_range(0, 99) < 5) ? NEWLINE_CODE : CHAR_W'($urandom_range(0, 255)),
               COL_IN_W'($urandom), ROW_IN_W'($urandom));
    end
  endtask

  // Random traffic: text runs dominate so the cursor walks down, wraps and
  // scrolls; cursor moves and reads in between, clears are rare (each one
  // costs a full sweep), plus some fully random commands.
  task automatic run_random(input int count);
    int stop_at;
    int r;
    stop_at = sent + count;
    while (sent < stop_at) begin
      r = $urandom_range(0, 999);
      if (r < 520)
        type_text($urandom_range(1, 40));
      else if (r < 700)
        send_cmd(CMD_SET, CHAR_W'($urandom), COL_IN_W'(pick_coord(COLS, 128)),
                 ROW_IN_W'(pick_coord(ROWS, 32)));
      else if (r < 900)
        send_cmd(CMD_READ, CHAR_W'($urandom), COL_IN_W'(pick_coord(COLS, 128)),
                 ROW_IN_W'(pick_coord(ROWS, 32)));
      else if (r < 985)
        send_cmd(cmd_t'($urandom_range(0, 3)), CHAR_W'($urandom), COL_IN_W'($urandom),
                 ROW_IN_W'($urandom));
      else
        send_cmd(CMD_CLEAR, CHAR_W'($urandom), COL_IN_W'($urandom), ROW_IN_W'($urandom));
    end
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_PUT;
    in_ch.char_code <= '0;
    in_ch.col       <= '0;
    in_ch.row       <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_TEXT_ATTR;
    cfg_ch.data     <= '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed part. The first read waits out the power-up sweep and must
    // see a zeroed cell.
    send_cmd(CMD_READ, 8'h00, 7'd0, 5'd0);
    drain();
    write_reg(CFG_TEXT_ATTR, 8'h5A);
    send_cmd(CMD_PUT, 8'h41, 7'd0, 5'd0);
    send_cmd(CMD_PUT, 8'hFF, 7'd0, 5'd0);
    send_cmd(CMD_PUT, 8'h00, 7'd0, 5'd0);
    send_cmd(CMD_PUT, NEWLINE_CODE, 7'd0, 5'd0);   // newline skips rest of line
    send_cmd(CMD_READ, 8'h00, 7'd1, 5'd0);
    send_cmd(CMD_SET, 8'h00, 7'd79, 5'd0);
    send_cmd(CMD_PUT, 8'h5A, 7'd0, 5'd0);          // last column, wraps
    send_cmd(CMD_SET, 8'hFF, 7'd127, 5'd31);       // saturates to bottom right
    send_cmd(CMD_PUT, 8'h80, 7'd0, 5'd0);          // wrap past last row: scroll
    send_cmd(CMD_READ, 8'h00, 7'd127, 5'd31);      // read saturates, blank fill
    send_cmd(CMD_READ, 8'h00, 7'd79, 5'd23);       // char moved up by the scroll
    send_cmd(CMD_PUT, NEWLINE_CODE, 7'd0, 5'd0);   // newline on last row scrolls
    send_cmd(CMD_SET, 8'h00, 7'd80, 5'd25);        // just out of range
    drain();
    write_reg(CFG_CURSOR_VISIBLE, 8'h00);          // hidden cursor reads as COLS
    send_cmd(CMD_PUT, 8'h71, 7'd0, 5'd0);
    send_cmd(CMD_SET, 8'h00, 7'd0, 5'd0);
    drain();
    write_reg(CFG_TEXT_ATTR, 8'hFF);
    write_reg(CFG_CURSOR_VISIBLE, 8'hFF);
    send_cmd(CMD_CLEAR, 8'h00, 7'd0, 5'd0);        // char 0 in attr, cursor home
    send_cmd(CMD_READ, 8'h00, 7'd40, 5'd12);
    send_cmd(CMD_SET, 8'h00, 7'd64, 5'd16);
    send_cmd(CMD_PUT, 8'h7F, 7'd0, 5'd0);
    send_cmd(CMD_READ, 8'h00, 7'd64, 5'd16);
    send_cmd(CMD_READ, 8'h00, 7'd0, 5'd31);
    send_cmd(CMD_PUT, NEWLINE_CODE, 7'd0, 5'd0);
    send_cmd(CMD_READ, 8'h00, 7'd127, 5'd0);

    // Random phase 1: random attribute, cursor shown, idling on.
    drain();
    write_reg(CFG_TEXT_ATTR, CFG_DAT_W'($urandom));
    write_reg(CFG_CURSOR_VISIBLE, {7'($urandom), 1'b1});
    run_random(450);

    // Random phase 2: full attribute, cursor hidden, no idling on either side.
    drain();
    idle_on <= 1'b0;
    write_reg(CFG_TEXT_ATTR, 8'hFF);
    write_reg(CFG_CURSOR_VISIBLE, {7'($urandom), 1'b0});
    run_random(350);

    // Random phase 3: zero attribute, cursor shown, idling back on.
    drain();
    idle_on <= 1'b1;
    write_reg(CFG_TEXT_ATTR, 8'h00);
    write_reg(CFG_CURSOR_VISIBLE, {7'($urandom), 1'b1});
    run_random(550);

    drain();
    repeat (SWEEP_CYCLES) @(negedge clk);
    if (failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
